>>> hdl/dstf_pkg.sv
// Shared types, constants and helpers for the decimal string parser.
// No dependencies; every module of the block imports this package.
package dstf_pkg;

	localparam int MAX_DIGITS = 9;
	localparam int FRAC_BITS  = 16;
	localparam int MANT_W     = 30;
	localparam int CNT_W      = 4;
	localparam int VALUE_W    = 47;
	localparam int STAT_W     = 2;
	localparam int DIVD_W     = MANT_W + FRAC_BITS;
	localparam int STEP_W     = $clog2(DIVD_W + 1);
	localparam int Q_DEPTH    = 2;
	localparam int QPTR_W     = $clog2(Q_DEPTH);
	localparam int QCNT_W     = $clog2(Q_DEPTH + 1);

	localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
	localparam logic [STAT_W-1:0] ST_BAD  = 2'd1;
	localparam logic [STAT_W-1:0] ST_OVER = 2'd2;

	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef struct packed {
		logic [MANT_W-1:0] mant;
		logic [CNT_W-1:0]  frac;
		logic              neg;
		logic [STAT_W-1:0] err;
	} job_t;

	function automatic logic [MANT_W-1:0] pow10(input logic [CNT_W-1:0] fd);
		logic [MANT_W-1:0] r;
		unique case (fd)
			4'd0:    r = 30'd1;
			4'd1:    r = 30'd10;
			4'd2:    r = 30'd100;
			4'd3:    r = 30'd1000;
			4'd4:    r = 30'd10000;
			4'd5:    r = 30'd100000;
			4'd6:    r = 30'd1000000;
			4'd7:    r = 30'd10000000;
			4'd8:    r = 30'd100000000;
			default: r = 30'd1000000000;
		endcase
		return r;
	endfunction

endpackage

>>> hdl/dstf_front.sv
// Character scanner: takes one character per cycle when acc is set and builds
// the digit mantissa, sign, point position and error code. Depends on dstf_pkg.
module dstf_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  acc,
	input  logic [7:0]            ch,
	input  logic                  last,
	output logic                  push,
	output dstf_pkg::job_t        job
);
	import dstf_pkg::*;

	logic [MANT_W-1:0] mant_q, mant_d;
	logic [CNT_W-1:0]  frac_q, frac_d, cnt_q, cnt_d;
	logic              point_q, point_d, neg_q, neg_d, start_q;
	logic [STAT_W-1:0] err_q, err_d;
	logic              is_digit;
	logic [MANT_W-1:0] digit;

	assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
	assign digit    = MANT_W'(ch - CH_ZERO);

	always_comb begin
		mant_d  = mant_q;
		frac_d  = frac_q;
		cnt_d   = cnt_q;
		point_d = point_q;
		neg_d   = neg_q;
		err_d   = err_q;
		if (err_q == ST_OK) begin
			priority if (is_digit) begin
				if (cnt_q >= CNT_W'(MAX_DIGITS)) begin
					err_d = ST_OVER;
				end else begin
					mant_d = (mant_q << 3) + (mant_q << 1) + digit;
					cnt_d  = cnt_q + 1'b1;
					if (point_q) frac_d = frac_q + 1'b1;
				end
			end else if (ch == CH_PLUS || ch == CH_MINUS) begin
				if (!start_q)              err_d = ST_BAD;
				else if (ch == CH_MINUS)   neg_d = 1'b1;
			end else if (ch == CH_POINT) begin
				if (point_q) err_d = ST_BAD;
				else         point_d = 1'b1;
			end else begin
				err_d = ST_BAD;
			end
		end
	end

	assign push = acc && last;
	assign job  = '{mant: mant_d, frac: frac_d, neg: neg_d, err: err_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mant_q  <= '0;
			frac_q  <= '0;
			cnt_q   <= '0;
			point_q <= 1'b0;
			neg_q   <= 1'b0;
			start_q <= 1'b1;
			err_q   <= ST_OK;
		end else if (acc) begin
			if (last) begin
				mant_q  <= '0;
				frac_q  <= '0;
				cnt_q   <= '0;
				point_q <= 1'b0;
				neg_q   <= 1'b0;
				start_q <= 1'b1;
				err_q   <= ST_OK;
			end else begin
				mant_q  <= mant_d;
				frac_q  <= frac_d;
				cnt_q   <= cnt_d;
				point_q <= point_d;
				neg_q   <= neg_d;
				start_q <= 1'b0;
				err_q   <= err_d;
			end
		end
	end

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != ST_OK && !(acc && last)) |=> err_q == $past(err_q))
		else $error("recorded error changed before end of string");

	a_frac_le_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		frac_q <= cnt_q && cnt_q <= CNT_W'(MAX_DIGITS))
		else $error("digit counters out of range");

endmodule

>>> hdl/dstf_queue.sv
// Short request queue between the scanner and the scaling unit.
// Depends on dstf_pkg for the job type and depth.
module dstf_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  dstf_pkg::job_t wr_job,
	input  logic           pop,
	output logic           full,
	output logic           nempty,
	output dstf_pkg::job_t rd_job
);
	import dstf_pkg::*;

	job_t              mem [Q_DEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full   = (cnt_q == QCNT_W'(Q_DEPTH));
	assign nempty = (cnt_q != '0);
	assign rd_job = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem[wr_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)  rd_q <= (rd_q == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |-> !full)
		else $error("request pushed into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> nempty)
		else $error("request popped from empty queue");

endmodule

>>> hdl/dstf_back.sv
// Scaling unit: divides mantissa * 2^FRAC_BITS by 10^fraction_digits one
// quotient bit per cycle, applies the sign and holds the result register.
// Requests with an error skip the divider and yield 0. Depends on dstf_pkg.
module dstf_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      nempty,
	input  dstf_pkg::job_t            job,
	output logic                      pop,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [dstf_pkg::VALUE_W-1:0] value,
	output logic [dstf_pkg::STAT_W-1:0]         status
);
	import dstf_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DIV  = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	logic [1:0]        state_q;
	logic [DIVD_W-1:0] quo_q;
	logic [MANT_W-1:0] rem_q, div_q;
	logic [STEP_W-1:0] step_q;
	logic              neg_q;
	logic [STAT_W-1:0] err_q;
	logic              ov_q;
	logic [MANT_W:0]   rem_sh;
	logic [MANT_W+1:0] trial;
	logic              slot_free;
	logic [VALUE_W-1:0] mag;

	assign rem_sh    = {rem_q, quo_q[DIVD_W-1]};
	assign trial     = {1'b0, rem_sh} - {2'b0, div_q};
	assign slot_free = !ov_q || !out_stall;
	assign pop       = (state_q == S_IDLE) && nempty;
	assign mag       = VALUE_W'(quo_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			ov_q    <= 1'b0;
		end else begin
			ov_q <= ((state_q == S_FIN) && slot_free) || (ov_q && out_stall);
			unique case (state_q)
				S_IDLE: begin
					if (nempty) begin
						if (job.err != ST_OK) state_q <= S_FIN;
						else                  state_q <= S_DIV;
						step_q <= STEP_W'(DIVD_W);
					end
				end
				S_DIV: begin
					step_q <= step_q - 1'b1;
					if (step_q == STEP_W'(1)) state_q <= S_FIN;
				end
				S_FIN: begin
					if (slot_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (nempty) begin
					quo_q <= (job.err != ST_OK) ? '0 : {job.mant, FRAC_BITS'(0)};
					rem_q <= '0;
					div_q <= pow10(job.frac);
					neg_q <= job.neg;
					err_q <= job.err;
				end
			end
			S_DIV: begin
				if (!trial[MANT_W+1]) begin
					rem_q <= trial[MANT_W-1:0];
					quo_q <= {quo_q[DIVD_W-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh[MANT_W-1:0];
					quo_q <= {quo_q[DIVD_W-2:0], 1'b0};
				end
			end
			S_FIN: begin
				if (slot_free) begin
					value  <= neg_q ? -mag : mag;
					status <= err_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = ov_q;

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> value == '0)
		else $error("error result carries nonzero value");

	a_div_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (step_q != '0 && step_q <= STEP_W'(DIVD_W)))
		else $error("divider step count out of range");

endmodule

>>> hdl/decimal_string_to_fixed.sv
// Decimal string to signed fixed-point converter (16 fraction bits).
// Characters are accepted one per cycle, back to back, while the request
// queue has room. The character flagged last closes the string; its request
// then passes a two-entry queue to a restoring divider that produces one
// quotient bit per cycle; it takes the next request only once it has handed
// the previous result on. Strings with an error skip the divider and report
// status 1 (bad character or format) or 2 (too many digits) with value 0.
// Depends on dstf_pkg, dstf_front, dstf_queue and dstf_back.
module decimal_string_to_fixed (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [7:0]                           ch,
	input  logic                                 last,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [dstf_pkg::VALUE_W-1:0]  value,
	output logic [dstf_pkg::STAT_W-1:0]          status
);
	import dstf_pkg::*;

	logic acc, push, pop, full, nempty;
	job_t wr_job, rd_job;

	assign in_stall = full;
	assign acc      = in_valid && !full;

	dstf_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.acc    (acc),
		.ch     (ch),
		.last   (last),
		.push   (push),
		.job    (wr_job)
	);

	dstf_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.pop    (pop),
		.full   (full),
		.nempty (nempty),
		.rd_job (rd_job)
	);

	dstf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.nempty    (nempty),
		.job       (rd_job),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value     (value),
		.status    (status)
	);

endmodule

>>> test/dstf_checker.sv
// Checker for the decimal string parser: predicts each result from the requests it
// sees on the input channel and compares it with the output channel.
// Depends on dstf_pkg; instantiated beside the block by tb_decimal_string_to_fixed.
module dstf_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic [7:0]                          ch,
	input  logic                                last,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic signed [dstf_pkg::VALUE_W-1:0] value,
	input  logic [dstf_pkg::STAT_W-1:0]         status,
	output int                                  failures,
	output int                                  pending,
	output int                                  results_checked,
	output int                                  chars_accepted
);
	timeunit 1ns;
	timeprecision 1ps;
	import dstf_pkg::*;

	logic [MANT_W-1:0]         mant;
	logic [CNT_W-1:0]          frac_digits;
	logic [CNT_W-1:0]          digits;
	logic                      point_seen;
	logic                      negative;
	logic                      at_start;
	logic [STAT_W-1:0]         err;
	logic signed [VALUE_W-1:0] value_q[$];
	logic [STAT_W-1:0]         status_q[$];

	always @(posedge clk) begin
		logic                      first;
		logic [63:0]               scaled;
		logic [63:0]               divisor;
		logic signed [VALUE_W-1:0] want_value;
		logic [STAT_W-1:0]         want_status;
		int                        i;
		if (!arst_n) begin
			mant = '0;
			frac_digits = '0;
			digits = '0;
			point_seen = 1'b0;
			negative = 1'b0;
			at_start = 1'b1;
			err = ST_OK;
			value_q.delete();
			status_q.delete();
		end else begin
			if (out_valid && !out_stall) begin
				results_checked++;
				if (value_q.size() == 0) begin
					$display("%0t: result with no string pending, got value %0d status %0d",
						$time, value, status);
					failures++;
				end else begin
					want_value = value_q.pop_front();
					want_status = status_q.pop_front();
					if (value !== want_value) begin
						$display("%0t: value mismatch, expected %0d, got %0d",
							$time, want_value, value);
						failures++;
					end
					if (status !== want_status) begin
						$display("%0t: status mismatch, expected %0d, got %0d",
							$time, want_status, status);
						failures++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				chars_accepted++;
				first = at_start;
				at_start = 1'b0;
				if (err == ST_OK) begin
					if (ch >= CH_ZERO && ch <= CH_NINE) begin
						if (digits >= MAX_DIGITS) begin
							err = ST_OVER;
						end else begin
							mant = mant * 10 + MANT_W'(ch - CH_ZERO);
							digits = digits + 1'b1;
							if (point_seen)
								frac_digits = frac_digits + 1'b1;
						end
					end else if (ch == CH_PLUS || ch == CH_MINUS) begin
						if (!first)
							err = ST_BAD;
						else if (ch == CH_MINUS)
							negative = 1'b1;
					end else if (ch == CH_POINT) begin
						if (point_seen)
							err = ST_BAD;
						else
							point_seen = 1'b1;
					end else begin
						err = ST_BAD;
					end
				end
				if (last) begin
					if (err != ST_OK) begin
						value_q.push_back('0);
						status_q.push_back(err);
					end else begin
						divisor = 64'd1;
						for (i = 0; i < frac_digits && i < MAX_DIGITS; i++)
							divisor = divisor * 10;
						scaled = (64'(mant) << FRAC_BITS) / divisor;
						if (negative)
							scaled = -scaled;
						value_q.push_back(scaled[VALUE_W-1:0]);
						status_q.push_back(ST_OK);
					end
					mant = '0;
					frac_digits = '0;
					digits = '0;
					point_seen = 1'b0;
					negative = 1'b0;
					at_start = 1'b1;
					err = ST_OK;
				end
			end
		end
		pending = value_q.size();
	end

endmodule

>>> test/tb_decimal_string_to_fixed.sv
// Top of the decimal string parser testbench: clock, reset, character stimulus
// with sender and receiver throttling, and the final verdict.
// Depends on dstf_pkg, decimal_string_to_fixed and dstf_checker.
module tb_decimal_string_to_fixed;
	timeunit 1ns;
	timeprecision 1ps;
	import dstf_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int HOLD_CYCLES = 400;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_stall;
	logic [7:0]                ch;
	logic                      last;
	logic                      out_valid;
	logic                      out_stall;
	logic signed [VALUE_W-1:0] value;
	logic [STAT_W-1:0]         status;

	int failures;
	int pending;
	int results_checked;
	int chars_accepted;
	int send_idle;
	int recv_idle;
	int cycles;
	bit hold_req;

	decimal_string_to_fixed dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.ch(ch),
		.last(last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.value(value),
		.status(status)
	);

	dstf_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.ch(ch),
		.last(last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.value(value),
		.status(status),
		.failures(failures),
		.pending(pending),
		.results_checked(results_checked),
		.chars_accepted(chars_accepted)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// hold off the output for a long stretch on request, else stall at random
	initial begin
		int hold;
		hold = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold > 0) begin
				out_stall <= 1'b1;
				hold--;
			end else begin
				out_stall <= ($urandom_range(0, 99) < recv_idle);
			end
		end
	end

	task automatic send_char(input logic [7:0] c, input logic fin);
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		ch <= c;
		last <= fin;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			send_char(s[i], i == s.len() - 1);
	endtask

	task automatic run_phase(input int quota, input int s_idle, input int r_idle, input bit hold);
		logic [7:0] text[$];
		int         kind;
		int         ndig;
		int         dot_at;
		int         i;
		int         sent;
		send_idle = s_idle;
		recv_idle = r_idle;
		hold_req = hold;
		sent = 0;
		while (sent < quota) begin
			text.delete();
			kind = $urandom_range(0, 99);
			if (kind < 5) begin
				text.push_back(8'($urandom_range(0, 255)));
			end else begin
				case ($urandom_range(0, 2))
					1: text.push_back(CH_PLUS);
					2: text.push_back(CH_MINUS);
					default: ;
				endcase
				if (kind >= 70 && kind < 80)
					ndig = $urandom_range(MAX_DIGITS + 1, MAX_DIGITS + 3);
				else
					ndig = $urandom_range(0, MAX_DIGITS);
				dot_at = $urandom_range(0, 1) ? $urandom_range(0, ndig) : -1;
				for (i = 0; i <= ndig; i++) begin
					if (i == dot_at)
						text.push_back(CH_POINT);
					if (i < ndig)
						text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
				end
				// corrupt the string with one stray character
				if (kind >= 80) begin
					case ($urandom_range(0, 2))
						0: text.insert($urandom_range(0, text.size()),
							8'($urandom_range(0, 255)));
						1: text.insert($urandom_range(0, text.size()),
							$urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
						default: text.insert($urandom_range(0, text.size()), CH_POINT);
					endcase
				end
				if (text.size() == 0)
					text.push_back(CH_ZERO);
			end
			foreach (text[k])
				send_char(text[k], k == text.size() - 1);
			sent += text.size();
		end
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
	endtask

	initial begin
		in_valid = 1'b0;
		ch = '0;
		last = 1'b0;
		arst_n = 1'b0;
		send_idle = 0;
		recv_idle = 0;
		hold_req = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle = 29;
		recv_idle = 80;
		send_text(".");
		send_text("-0");
		send_text("-999999999");
		send_text(".0123456789");
		send_text("1..+");
		send_text("5-");
		send_char(8'h00, 1'b1);
		send_char(8'hFF, 1'b1);

		run_phase(300, 29, 80, 1'b0);
		run_phase(300, 80, 29, 1'b0);
		run_phase(300, 0, 0, 1'b1);
		repeat (100) @(negedge clk);

		$display("Ran %0d characters forming %0d strings: directed edge cases, then random",
			chars_accepted, results_checked);
		$display("strings under sender and receiver throttling and a long output hold-off.");
		if (failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

>>> sim.f
hdl/dstf_pkg.sv
hdl/dstf_front.sv
hdl/dstf_queue.sv
hdl/dstf_back.sv
hdl/decimal_string_to_fixed.sv
test/dstf_checker.sv
test/tb_decimal_string_to_fixed.sv
